@@ rtl/core/sbr_pkg.sv @@
// Package for the SBUS frame receiver.
// Holds frame constants, the frame event type and the channel unpacking function.
// No dependencies.
package sbr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int FILL_W       = 5;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam int IDX_W        = 4;
    localparam int CHAN_BYTES   = 22;
    localparam int FLAGS_AT     = 23;

    localparam logic [7:0] HEADER_BYTE      = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE      = 8'h00;
    localparam logic [7:0] FLAG_REJECT_MASK = 8'hFC;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef logic [NUM_CHANNELS-1:0][CHAN_BITS-1:0] chan_array_t;

    typedef struct packed {
        logic        hit;
        logic        reject;
        chan_array_t chans;
    } frame_evt_t;

    function automatic chan_array_t unpack_channels(
        input logic [CHAN_BYTES*8-1:0] bits
    );
        chan_array_t r;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            r[i] = bits[i*CHAN_BITS +: CHAN_BITS];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/sbr_window.sv @@
// Byte window of the SBUS frame receiver with fill count and frame detection.
// Depends on sbr_pkg.
module sbr_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output sbr_pkg::frame_evt_t evt
);

    logic [sbr_pkg::FRAME_BYTES-1:0][7:0] win_reg;
    logic [sbr_pkg::FRAME_BYTES-1:0][7:0] win_next;
    logic [sbr_pkg::FILL_W-1:0]           fill_reg;
    logic [sbr_pkg::FILL_W-1:0]           fill_next;
    logic [sbr_pkg::CHAN_BYTES*8-1:0]     chan_bits;
    logic                                 full_next;

    always_comb begin
        for (int i = 0; i < sbr_pkg::FRAME_BYTES - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[sbr_pkg::FRAME_BYTES-1] = rx_byte;
        for (int j = 0; j < sbr_pkg::CHAN_BYTES; j++) begin
            chan_bits[8*j +: 8] = win_next[j+1];
        end
    end

    assign full_next  = (fill_reg >= sbr_pkg::FILL_W'(sbr_pkg::FRAME_BYTES - 1));
    assign evt.hit    = full_next
                     && (win_next[0] == sbr_pkg::HEADER_BYTE)
                     && (win_next[sbr_pkg::FRAME_BYTES-1] == sbr_pkg::FOOTER_BYTE);
    assign evt.reject = (win_next[sbr_pkg::FLAGS_AT] & sbr_pkg::FLAG_REJECT_MASK) != 8'h00;
    assign evt.chans  = sbr_pkg::unpack_channels(chan_bits);

    always_comb begin
        if (evt.hit && !evt.reject) begin
            fill_next = '0;
        end else if (fill_reg == sbr_pkg::FILL_W'(sbr_pkg::FRAME_BYTES)) begin
            fill_next = fill_reg;
        end else begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

@@ rtl/core/sbr_drain.sv @@
// Result register of the SBUS frame receiver that drains one held frame.
// Depends on sbr_pkg.
module sbr_drain (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  sbr_pkg::frame_evt_t           evt,
    output logic                          can_load,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [sbr_pkg::IDX_W-1:0]     m_channel_index,
    output logic [sbr_pkg::CHAN_BITS-1:0] m_channel_value,
    output logic                          m_last
);

    logic                        busy_reg;
    logic                        reject_reg;
    logic [sbr_pkg::IDX_W-1:0]   idx_reg;
    sbr_pkg::chan_array_t        chans_reg;
    logic                        last_out;

    assign last_out = reject_reg || (idx_reg == sbr_pkg::IDX_W'(sbr_pkg::NUM_CHANNELS - 1));
    assign can_load = !busy_reg || (m_ready && last_out);

    assign m_valid         = busy_reg;
    assign m_status        = reject_reg ? sbr_pkg::STATUS_REJECT : sbr_pkg::STATUS_OK;
    assign m_channel_index = idx_reg;
    assign m_channel_value = reject_reg ? '0 : chans_reg[idx_reg];
    assign m_last          = last_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && m_ready && last_out) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            reject_reg <= evt.reject;
            idx_reg    <= '0;
            chans_reg  <= evt.chans;
        end else if (busy_reg && m_ready && !last_out) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

@@ rtl/core/sbus_frame_receiver.sv @@
// SBUS frame receiver: one byte per cycle, results appear in the cycle after the closing byte is accepted.
// An accepted frame gives sixteen results at one per cycle while m_ready is high; a rejected frame gives one.
// A byte is stalled only when it completes a frame while the previous frame still drains.
// The held frame register drains while the next bytes fill the 25-byte window.
// Synchronous active-low reset empties the window count and drops the output valid.
// Depends on sbr_pkg, sbr_window and sbr_drain.
module sbus_frame_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [sbr_pkg::IDX_W-1:0]     m_channel_index,
    output logic [sbr_pkg::CHAN_BITS-1:0] m_channel_value,
    output logic                          m_last
);

    sbr_pkg::frame_evt_t evt;
    logic                can_load;
    logic                accept;
    logic                load;

    assign s_ready = can_load || !evt.hit;
    assign accept  = s_valid && s_ready;
    assign load    = accept && evt.hit;

    sbr_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .evt     (evt)
    );

    sbr_drain u_drain (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .evt             (evt),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last          (m_last)
    );

`ifndef SYNTH
    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last && m_channel_index == '0 && m_channel_value == '0))
        else $error("Rejected frame transaction is malformed.");

    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("Frame loaded while the previous frame was still draining.");

    a_frame_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && !m_status))
        else $error("Frame ended before its last channel.");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_channel_index == $past(m_channel_index) + 1'b1))
        else $error("Channel index did not advance by one.");
`endif

endmodule

@@ tb/tb_sbus_frame_receiver.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sbus_frame_receiver: feeds serial bytes and checks decoded channels.
// Expected results come from a byte-level frame decoder kept in step with accepted bytes.
// Depends on sbr_pkg and the sbus_frame_receiver RTL.
module tb_sbus_frame_receiver;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 20;
    localparam int TARGET_BYTES = 280;

    typedef struct {
        logic                          status;
        logic [sbr_pkg::IDX_W-1:0]     index;
        logic [sbr_pkg::CHAN_BITS-1:0] value;
        logic                          last;
    } channel_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_rx_byte;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_status;
    logic [sbr_pkg::IDX_W-1:0]     m_channel_index;
    logic [sbr_pkg::CHAN_BITS-1:0] m_channel_value;
    logic                          m_last;

    logic [7:0]      rx_pending[$];
    channel_result_t channel_results_due[$];

    logic [7:0] rx_window [sbr_pkg::FRAME_BYTES];
    int         wr_pos;
    int         fill_cnt;

    int error_count;
    int bytes_taken;
    int results_seen;
    int send_wait;
    int send_max;
    int recv_wait;
    int recv_max;
    int hold_left;
    int idle_cycles;

    sbus_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void decode_rx_byte(input logic [7:0] b);
        logic [7:0]      frame [sbr_pkg::FRAME_BYTES];
        logic [23:0]     gather;
        logic [23:0]     shifted;
        channel_result_t r;
        int              k;
        int              bitpos;
        int              at;
        rx_window[wr_pos] = b;
        wr_pos = (wr_pos + 1) % sbr_pkg::FRAME_BYTES;
        if (fill_cnt < sbr_pkg::FRAME_BYTES) begin
            fill_cnt++;
        end
        if (fill_cnt != sbr_pkg::FRAME_BYTES) begin
            return;
        end
        for (k = 0; k < sbr_pkg::FRAME_BYTES; k++) begin
            frame[k] = rx_window[(wr_pos + k) % sbr_pkg::FRAME_BYTES];
        end
        if (frame[0] != sbr_pkg::HEADER_BYTE
            || frame[sbr_pkg::FRAME_BYTES-1] != sbr_pkg::FOOTER_BYTE) begin
            return;
        end
        if ((frame[sbr_pkg::FLAGS_AT] & sbr_pkg::FLAG_REJECT_MASK) != 8'h00) begin
            r.status = sbr_pkg::STATUS_REJECT;
            r.index  = '0;
            r.value  = '0;
            r.last   = 1'b1;
            channel_results_due.push_back(r);
            return;
        end
        for (k = 0; k < sbr_pkg::NUM_CHANNELS; k++) begin
            bitpos   = k * sbr_pkg::CHAN_BITS;
            at       = 1 + bitpos / 8;
            gather   = {frame[at+2], frame[at+1], frame[at]};
            shifted  = gather >> (bitpos % 8);
            r.status = sbr_pkg::STATUS_OK;
            r.index  = k[sbr_pkg::IDX_W-1:0];
            r.value  = shifted[sbr_pkg::CHAN_BITS-1:0];
            r.last   = (k == sbr_pkg::NUM_CHANNELS - 1);
            channel_results_due.push_back(r);
        end
        wr_pos   = 0;
        fill_cnt = 0;
    endfunction

    task automatic queue_frame(input logic [7:0] head, input logic [7:0] flags,
                               input logic [7:0] foot, input bit lead_header);
        int         fill_mode;
        int         k;
        logic [7:0] pb;
        fill_mode = $urandom_range(0, 3);
        rx_pending.push_back(head);
        for (k = 1; k <= sbr_pkg::CHAN_BYTES; k++) begin
            case (fill_mode)
                0: pb = 8'($urandom);
                1: pb = 8'hFF;
                2: pb = 8'h00;
                default: begin
                    if ($urandom_range(0, 1)) begin
                        pb = 8'($urandom);
                    end else begin
                        pb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                end
            endcase
            if (k == 1 && lead_header) begin
                pb = sbr_pkg::HEADER_BYTE;
            end
            rx_pending.push_back(pb);
        end
        rx_pending.push_back(flags);
        rx_pending.push_back(foot);
    endtask

    task automatic build_stimulus();
        int         kind;
        int         n;
        int         k;
        bit         lead;
        logic [7:0] flags;
        // A few bytes that cannot complete a frame, then a frame with every channel at
        // full scale and the two ignored flag bits set.
        rx_pending.push_back(sbr_pkg::HEADER_BYTE);
        rx_pending.push_back(sbr_pkg::FOOTER_BYTE);
        rx_pending.push_back(8'hAA);
        rx_pending.push_back(sbr_pkg::HEADER_BYTE);
        for (k = 1; k <= sbr_pkg::CHAN_BYTES; k++) begin
            rx_pending.push_back(8'hFF);
        end
        rx_pending.push_back(8'h03);
        rx_pending.push_back(sbr_pkg::FOOTER_BYTE);

        while (rx_pending.size() < TARGET_BYTES) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                flags = 8'($urandom_range(0, 3));
                queue_frame(sbr_pkg::HEADER_BYTE, flags, sbr_pkg::FOOTER_BYTE, 1'b0);
            end else if (kind <= 7) begin
                // A rejected frame stays in the window. When its second byte is a header,
                // one more zero byte slides it into a frame that is accepted.
                flags = 8'h04 << $urandom_range(0, 5);
                if ($urandom_range(0, 1)) begin
                    flags = flags | 8'($urandom);
                end
                lead = 1'($urandom_range(0, 1));
                queue_frame(sbr_pkg::HEADER_BYTE, flags, sbr_pkg::FOOTER_BYTE, lead);
                if (lead) begin
                    rx_pending.push_back(sbr_pkg::FOOTER_BYTE);
                end
            end else if (kind == 8) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    rx_pending.push_back(8'($urandom));
                end
            end else begin
                flags = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    queue_frame(sbr_pkg::HEADER_BYTE ^ (8'h01 << $urandom_range(0, 7)), flags,
                                sbr_pkg::FOOTER_BYTE, 1'b0);
                end else begin
                    queue_frame(sbr_pkg::HEADER_BYTE, flags, 8'h01 << $urandom_range(0, 7),
                                1'b0);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                decode_rx_byte(s_rx_byte);
                bytes_taken++;
                if (bytes_taken % 40 == 0) begin
                    send_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                    send_wait = $urandom_range(0, send_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        channel_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (channel_results_due.size() == 0) begin
                    flag_error($sformatf("result with none expected: idx %0d value %0d",
                                         m_channel_index, m_channel_value));
                end else begin
                    want = channel_results_due.pop_front();
                    if (m_status !== want.status) begin
                        flag_error($sformatf("status %b, expected %b", m_status, want.status));
                    end
                    if (m_channel_index !== want.index) begin
                        flag_error($sformatf("channel_index %0d, expected %0d",
                                             m_channel_index, want.index));
                    end
                    if (m_channel_value !== want.value) begin
                        flag_error($sformatf("channel_value %0d, expected %0d on channel %0d",
                                             m_channel_value, want.value, want.index));
                    end
                    if (m_last !== want.last) begin
                        flag_error($sformatf("last %b, expected %b", m_last, want.last));
                    end
                end
                recv_wait = $urandom_range(0, recv_max);
                if (results_seen % 40 == 0) begin
                    recv_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
                end
                if (results_seen == 32 || results_seen == 96) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_sbus_frame_receiver failed");
                $finish;
            end
        end
    end

    initial begin
        int k;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = 8'h00;
        m_ready      = 1'b0;
        error_count  = 0;
        bytes_taken  = 0;
        results_seen = 0;
        send_wait    = 0;
        send_max     = 4;
        recv_wait    = 0;
        recv_max     = 4;
        hold_left    = 0;
        idle_cycles  = 0;
        wr_pos       = 0;
        fill_cnt     = 0;
        for (k = 0; k < sbr_pkg::FRAME_BYTES; k++) begin
            rx_window[k] = 8'h00;
        end
        build_stimulus();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do begin
            @(posedge aclk);
        end while (rx_pending.size() > 0 || s_valid || channel_results_due.size() > 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (channel_results_due.size() > 0) begin
            flag_error($sformatf("%0d results never arrived", channel_results_due.size()));
        end
        if (error_count == 0) begin
            $display("tb_sbus_frame_receiver passed");
        end else begin
            $display("tb_sbus_frame_receiver failed");
        end
        $finish;
    end

endmodule

@@ sbus_frame_receiver.f @@
rtl/core/sbr_pkg.sv
rtl/core/sbr_window.sv
rtl/core/sbr_drain.sv
rtl/core/sbus_frame_receiver.sv
tb/tb_sbus_frame_receiver.sv
